/* rtl/dsss_pkg.sv */
// Package: constants, register indexes and control struct of the DSSS despreading correlator.
package dsss_pkg;

   localparam int SAMPLES_PER_CHIP = 10;
   localparam int SAMPLE_WIDTH     = 8;
   localparam int SIC_WIDTH        = (SAMPLES_PER_CHIP > 1) ? $clog2(SAMPLES_PER_CHIP) : 1;
   localparam int ACC_WIDTH        = 18;
   localparam int SUM_WIDTH        = ACC_WIDTH + 1;
   localparam int LEN_WIDTH        = 7;
   localparam int CHIP_WIDTH       = 6;
   localparam int MAX_CHIPS        = 64;
   localparam int SKIP_WIDTH       = 16;
   localparam int CSR_DATA_WIDTH   = 64;
   localparam int CSR_INDEX_WIDTH  = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CODE_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CODE_CHIPS   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SKIP_SAMPLES = 2'd2;

   localparam logic [LEN_WIDTH-1:0] CODE_LENGTH_RESET = 7'd8;

   typedef struct packed {
      logic skip;
      logic chip_pos;
      logic emit;
   } dsss_ctrl_type;

endpackage

/* rtl/dsss_despread_correlator_top.sv */
// Top level: DSSS despreading correlator with config registers, accumulator and result register.
// A result is registered and appears on rsp_ in the cycle after the item that closes its bit period is accepted.
// Throughput: one sample per cycle; the input stalls only when the next sample closes a bit
// period while the previous result is still held in the single result register.
// Reset: synchronous, active high; clears counters, accumulator and result valid, and loads
// code_length 8, code_chips 0 and skip_samples 0.
module dsss_despread_correlator_top (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [dsss_pkg::SAMPLE_WIDTH-1:0]   req_sample,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic                                       rsp_bit_value,
   output logic signed [dsss_pkg::ACC_WIDTH-1:0]      rsp_correlation,
   input  logic                                       csr_we,
   input  logic [dsss_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [dsss_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);

   logic [dsss_pkg::LEN_WIDTH-1:0]           code_length_ff;
   logic [dsss_pkg::MAX_CHIPS-1:0]           code_chips_ff;
   logic [dsss_pkg::SKIP_WIDTH-1:0]          skip_samples_ff;
   logic signed [dsss_pkg::ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic signed [dsss_pkg::SUM_WIDTH-1:0]    product;
   logic signed [dsss_pkg::SUM_WIDTH-1:0]    sum;
   logic signed [dsss_pkg::ACC_WIDTH-1:0]    sat_sum;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     rsp_bit_ff;
   logic signed [dsss_pkg::ACC_WIDTH-1:0]    rsp_corr_ff;
   logic                                     accept;
   dsss_pkg::dsss_ctrl_type                  ctrl;

   localparam logic signed [dsss_pkg::SUM_WIDTH-1:0] ACC_MAX =
      dsss_pkg::SUM_WIDTH'((1 << (dsss_pkg::ACC_WIDTH - 1)) - 1);
   localparam logic signed [dsss_pkg::SUM_WIDTH-1:0] ACC_MIN =
      -dsss_pkg::SUM_WIDTH'(1 << (dsss_pkg::ACC_WIDTH - 1));

   assign req_ready = !ctrl.emit || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   dsss_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .code_length  (code_length_ff),
      .code_chips   (code_chips_ff),
      .skip_samples (skip_samples_ff),
      .ctrl         (ctrl)
   );

   always_comb begin
      product = dsss_pkg::SUM_WIDTH'(req_sample);
      if (!ctrl.chip_pos) begin
         product = -product;
      end
      sum = dsss_pkg::SUM_WIDTH'(acc_ff) + product;
      priority if (sum > ACC_MAX) begin
         sat_sum = dsss_pkg::ACC_WIDTH'(ACC_MAX);
      end else if (sum < ACC_MIN) begin
         sat_sum = dsss_pkg::ACC_WIDTH'(ACC_MIN);
      end else begin
         sat_sum = dsss_pkg::ACC_WIDTH'(sum);
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && !ctrl.skip) begin
         acc_in = ctrl.emit ? '0 : sat_sum;
         if (ctrl.emit) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_length_ff  <= dsss_pkg::CODE_LENGTH_RESET;
         code_chips_ff   <= '0;
         skip_samples_ff <= '0;
         acc_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               dsss_pkg::CSR_CODE_LENGTH: begin
                  code_length_ff <= csr_wdata[dsss_pkg::LEN_WIDTH-1:0];
               end
               dsss_pkg::CSR_CODE_CHIPS: begin
                  code_chips_ff <= csr_wdata[dsss_pkg::MAX_CHIPS-1:0];
               end
               dsss_pkg::CSR_SKIP_SAMPLES: begin
                  skip_samples_ff <= csr_wdata[dsss_pkg::SKIP_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && ctrl.emit) begin
         rsp_bit_ff  <= !sat_sum[dsss_pkg::ACC_WIDTH-1];
         rsp_corr_ff <= sat_sum;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bit_value   = rsp_bit_ff;
   assign rsp_correlation = rsp_corr_ff;

endmodule

/* rtl/dsss_sequencer.sv */
// Sequencer: skip, sample-in-chip and chip counters, chip selection and end-of-bit decision.
module dsss_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [dsss_pkg::LEN_WIDTH-1:0]       code_length,
   input  logic [dsss_pkg::MAX_CHIPS-1:0]       code_chips,
   input  logic [dsss_pkg::SKIP_WIDTH-1:0]      skip_samples,
   output dsss_pkg::dsss_ctrl_type              ctrl
);

   logic [dsss_pkg::SKIP_WIDTH-1:0] skip_count_ff, skip_count_in;
   logic [dsss_pkg::SIC_WIDTH-1:0]  sample_ff, sample_in;
   logic [dsss_pkg::CHIP_WIDTH-1:0] chip_ff, chip_in;
   logic [dsss_pkg::LEN_WIDTH-1:0]  len_eff;
   logic                            last_sample;
   logic                            last_chip;

   always_comb begin
      priority if (code_length == '0) begin
         len_eff = dsss_pkg::LEN_WIDTH'(1);
      end else if (code_length > dsss_pkg::LEN_WIDTH'(dsss_pkg::MAX_CHIPS)) begin
         len_eff = dsss_pkg::LEN_WIDTH'(dsss_pkg::MAX_CHIPS);
      end else begin
         len_eff = code_length;
      end
   end

   assign last_sample = (sample_ff == dsss_pkg::SIC_WIDTH'(dsss_pkg::SAMPLES_PER_CHIP - 1));
   assign last_chip   = (({1'b0, chip_ff} + dsss_pkg::LEN_WIDTH'(1)) >= len_eff);

   assign ctrl.skip     = (skip_count_ff < skip_samples);
   assign ctrl.chip_pos = code_chips[chip_ff];
   assign ctrl.emit     = !ctrl.skip && last_sample && last_chip;

   always_comb begin
      skip_count_in = skip_count_ff;
      sample_in     = sample_ff;
      chip_in       = chip_ff;
      if (advance) begin
         if (ctrl.skip) begin
            skip_count_in = skip_count_ff + dsss_pkg::SKIP_WIDTH'(1);
         end else if (!last_sample) begin
            sample_in = sample_ff + dsss_pkg::SIC_WIDTH'(1);
         end else begin
            sample_in = '0;
            chip_in   = last_chip ? '0 : chip_ff + dsss_pkg::CHIP_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_count_ff <= '0;
         sample_ff     <= '0;
         chip_ff       <= '0;
      end else begin
         skip_count_ff <= skip_count_in;
         sample_ff     <= sample_in;
         chip_ff       <= chip_in;
      end
   end

endmodule

/* rtl/dsss_checker.sv */
// Checker: port-level assertions on the DSSS despreading correlator, bound to the top level.
module dsss_checker (
   input logic                                       clock,
   input logic                                       reset,
   input logic                                       req_valid,
   input logic                                       req_ready,
   input logic                                       rsp_valid,
   input logic                                       rsp_ready,
   input logic                                       rsp_bit_value,
   input logic signed [dsss_pkg::ACC_WIDTH-1:0]      rsp_correlation
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_correlation)
         && $stable(rsp_bit_value))
      else $error("stalled item changed");

   a_bit_matches_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bit_value == !rsp_correlation[dsss_pkg::ACC_WIDTH-1])
      else $error("decided bit disagrees with correlation sign");

   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an accepted item");

endmodule

bind dsss_despread_correlator_top dsss_checker u_checker (.*);

/* verif/tb_top.sv */
// Testbench for the DSSS despreading correlator: random stalls, bit-level prediction and checking.
module tb_top;

   localparam int ACC_MAX = 2 ** (dsss_pkg::ACC_WIDTH - 1) - 1;
   localparam int ACC_MIN = -(2 ** (dsss_pkg::ACC_WIDTH - 1));

   typedef struct {
      logic                                  bit_value;
      logic signed [dsss_pkg::ACC_WIDTH-1:0] correlation;
   } decided_bit_type;

   class despread_tracker;
      logic [dsss_pkg::LEN_WIDTH-1:0]  code_length;
      logic [63:0]                     code_chips;
      logic [dsss_pkg::SKIP_WIDTH-1:0] skip_samples;
      logic [dsss_pkg::SKIP_WIDTH-1:0] skip_count;
      int                              sample_in_chip;
      int                              chip_index;
      int                              acc;
      decided_bit_type                 pending_bits[$];
      int                              bits_checked;
      int                              mismatches;

      function new();
         code_length    = dsss_pkg::CODE_LENGTH_RESET;
         code_chips     = '0;
         skip_samples   = '0;
         skip_count     = '0;
         sample_in_chip = 0;
         chip_index     = 0;
         acc            = 0;
         bits_checked   = 0;
         mismatches     = 0;
      endfunction

      function void set_reg(logic [dsss_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [dsss_pkg::CSR_DATA_WIDTH-1:0] val);
         case (idx)
            dsss_pkg::CSR_CODE_LENGTH:  code_length  = val[dsss_pkg::LEN_WIDTH-1:0];
            dsss_pkg::CSR_CODE_CHIPS:   code_chips   = val;
            dsss_pkg::CSR_SKIP_SAMPLES: skip_samples = val[dsss_pkg::SKIP_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function int chip_now();
         return code_chips[chip_index] ? 1 : -1;
      endfunction

      function bit at_bit_start();
         return chip_index == 0 && sample_in_chip == 0;
      endfunction

      function int pending();
         return pending_bits.size();
      endfunction

      function void take_sample(logic signed [dsss_pkg::SAMPLE_WIDTH-1:0] s);
         int              sv;
         int              sum;
         int              len;
         decided_bit_type d;
         sv = int'(s);
         if (skip_count < skip_samples) begin
            skip_count = skip_count + dsss_pkg::SKIP_WIDTH'(1);
            return;
         end
         sum = acc + (code_chips[chip_index] ? sv : -sv);
         if (sum > ACC_MAX) sum = ACC_MAX;
         if (sum < ACC_MIN) sum = ACC_MIN;
         acc = sum;
         if (sample_in_chip + 1 < dsss_pkg::SAMPLES_PER_CHIP) begin
            sample_in_chip++;
            return;
         end
         sample_in_chip = 0;
         if (code_length == 0) len = 1;
         else if (int'(code_length) > dsss_pkg::MAX_CHIPS) len = dsss_pkg::MAX_CHIPS;
         else len = int'(code_length);
         if (chip_index + 1 < len) begin
            chip_index++;
            return;
         end
         chip_index    = 0;
         d.bit_value   = (acc >= 0);
         d.correlation = acc[dsss_pkg::ACC_WIDTH-1:0];
         pending_bits.push_back(d);
         acc = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_bit(logic bv, logic signed [dsss_pkg::ACC_WIDTH-1:0] corr);
         decided_bit_type want;
         if (pending_bits.size() == 0) begin
            report($sformatf("unexpected bit %0b correlation %0d", bv, corr));
            return;
         end
         want = pending_bits.pop_front();
         bits_checked++;
         if (bv !== want.bit_value)
            report($sformatf("bit %0d: bit_value %0b, want %0b", bits_checked, bv,
                             want.bit_value));
         if (corr !== want.correlation)
            report($sformatf("bit %0d: correlation %0d, want %0d", bits_checked, corr,
                             want.correlation));
      endtask
   endclass

   logic                                       clock;
   logic                                       reset;
   logic                                       req_valid;
   logic                                       req_ready;
   logic signed [dsss_pkg::SAMPLE_WIDTH-1:0]   req_sample;
   logic                                       rsp_valid;
   logic                                       rsp_ready;
   logic                                       rsp_bit_value;
   logic signed [dsss_pkg::ACC_WIDTH-1:0]      rsp_correlation;
   logic                                       csr_we;
   logic [dsss_pkg::CSR_INDEX_WIDTH-1:0]       csr_index;
   logic [dsss_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata;

   despread_tracker tracker;
   bit              quiet;
   int              samples_sent;

   dsss_despread_correlator_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bit_value   (rsp_bit_value),
      .rsp_correlation (rsp_correlation),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

   // receiver stalls in random bursts
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            repeat ($urandom_range(0, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_bit(rsp_bit_value, rsp_correlation);
   end

   task automatic send_sample(input logic signed [dsss_pkg::SAMPLE_WIDTH-1:0] s);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      tracker.take_sample(s);
      samples_sent++;
   endtask

   // drop valid, wait out every pending bit plus the result latency
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [dsss_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [dsss_pkg::CSR_DATA_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_reg(idx, val);
      @(posedge clock);
   endtask

   function automatic logic signed [dsss_pkg::SAMPLE_WIDTH-1:0] spread_sample(int data_sign,
                                                                              int amp);
      int v;
      v = tracker.chip_now() * data_sign * amp + int'($urandom_range(0, 60)) - 30;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return v[dsss_pkg::SAMPLE_WIDTH-1:0];
   endfunction

   initial begin
      int                             n;
      int                             amp;
      int                             data_sign;
      int                             wait_cycles;
      bit                             spread_mode;
      logic [63:0]                    chips;
      logic [dsss_pkg::LEN_WIDTH-1:0] len;

      tracker      = new();
      quiet        = 1'b0;
      samples_sent = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      csr_we       = 1'b0;
      csr_index    = dsss_pkg::CSR_CODE_LENGTH;
      csr_wdata    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // skip, zero code length, extreme samples
      write_reg(dsss_pkg::CSR_SKIP_SAMPLES, 64'd3);
      write_reg(dsss_pkg::CSR_CODE_LENGTH, 64'd0);
      write_reg(dsss_pkg::CSR_CODE_CHIPS, 64'hFFFF_FFFF_FFFF_FFFE);
      for (int i = 0; i < 3; i++) send_sample(8'sd127);
      for (int i = 0; i < 10; i++) send_sample(8'sd127);
      for (int i = 0; i < 10; i++) send_sample(-8'sd128);
      settle();

      // skip register raised to the top, then lowered below the count
      write_reg(dsss_pkg::CSR_SKIP_SAMPLES, 64'd65535);
      send_sample(-8'sd1);
      send_sample(8'sd1);
      settle();
      write_reg(dsss_pkg::CSR_SKIP_SAMPLES, 64'd0);

      // code length lowered past the current chip
      write_reg(dsss_pkg::CSR_CODE_LENGTH, 64'd2);
      write_reg(dsss_pkg::CSR_CODE_CHIPS, 64'h5);
      for (int i = 0; i < 15; i++) send_sample(i[0] ? -8'sd1 : 8'sd0);
      settle();
      write_reg(dsss_pkg::CSR_CODE_LENGTH, 64'd1);
      for (int i = 0; i < 5; i++) send_sample(8'sd1);
      settle();

      // out-of-range code length clamps to the longest code, most negative sum
      write_reg(dsss_pkg::CSR_CODE_LENGTH, 64'd127);
      write_reg(dsss_pkg::CSR_CODE_CHIPS, '1);
      for (int i = 0; i < 640; i++) send_sample(-8'sd128);
      settle();

      while (samples_sent < 1500) begin
         if (samples_sent >= 1300) quiet = 1'b1;
         if ($urandom_range(0, 9) < 7) len = dsss_pkg::LEN_WIDTH'($urandom_range(1, 4));
         else if ($urandom_range(0, 4) == 0) len = '0;
         else len = dsss_pkg::LEN_WIDTH'($urandom_range(5, 16));
         case ($urandom_range(0, 5))
            0: chips = '0;
            1: chips = '1;
            default: chips = {$urandom, $urandom};
         endcase
         write_reg(dsss_pkg::CSR_CODE_LENGTH, dsss_pkg::CSR_DATA_WIDTH'(len));
         write_reg(dsss_pkg::CSR_CODE_CHIPS, chips);
         if ($urandom_range(0, 7) == 0)
            write_reg(dsss_pkg::CSR_SKIP_SAMPLES,
                      dsss_pkg::CSR_DATA_WIDTH'($urandom_range(0, 8)));
         n           = $urandom_range(30, 160);
         spread_mode = ($urandom_range(0, 3) != 0);
         amp         = $urandom_range(10, 110);
         data_sign   = 1;
         for (int i = 0; i < n; i++) begin
            if (tracker.at_bit_start()) data_sign = $urandom_range(0, 1) ? 1 : -1;
            if (spread_mode) send_sample(spread_sample(data_sign, amp));
            else send_sample(dsss_pkg::SAMPLE_WIDTH'($urandom_range(0, 255)));
         end
         settle();
      end

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (tracker.pending() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d bits never came out", tracker.pending()));

      $display("%0d samples sent, %0d decided bits checked", samples_sent,
               tracker.bits_checked);
      $display("code lengths 0 to 127, skip up to 65535, mid-bit length changes covered");
      if (tracker.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/dsss_pkg.sv
rtl/dsss_sequencer.sv
rtl/dsss_despread_correlator_top.sv
rtl/dsss_checker.sv
verif/tb_top.sv
